// ===== src/dsre_pkg.sv =====
package dsre_pkg;

   // Width of one stack word
   localparam int unsigned WORD_W = 32;

   // Operation codes as they arrive on req_opcode
   typedef enum logic [3:0] {
      OP_SA    = 4'd0,
      OP_SB    = 4'd1,
      OP_SS    = 4'd2,
      OP_PA    = 4'd3,
      OP_PB    = 4'd4,
      OP_RA    = 4'd5,
      OP_RB    = 4'd6,
      OP_RR    = 4'd7,
      OP_RRA   = 4'd8,
      OP_RRB   = 4'd9,
      OP_RRR   = 4'd10,
      OP_LOAD  = 4'd11,
      OP_CLEAR = 4'd12
   } op_type;

   // Outcome codes on rsp_status
   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FEW  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Per-stack action; the top level only issues an action that is allowed
   typedef enum logic [2:0] {
      STK_NOP,
      STK_SWAP,
      STK_ROT,
      STK_RROT,
      STK_POP,
      STK_PUSH,
      STK_LOAD,
      STK_CLEAR
   } stk_kind_type;

   // Execute-stage command to one stack
   typedef struct packed {
      stk_kind_type        kind;
      logic [WORD_W-1:0]   data;
   } stk_cmd_type;

endpackage

// ===== src/dsre_stack.sv =====
// One bounded stack: top word in a register, the rest in a circular buffer.
// Element i from the top (i >= 1) sits at (head + i) mod DEPTH in memory.
module dsre_stack
   import dsre_pkg::*;
#(
   parameter int unsigned DEPTH = 512,
   localparam int unsigned AW = $clog2(DEPTH),
   localparam int unsigned CW = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  stk_kind_type      rd_kind,
   input  stk_cmd_type       cmd,
   output logic [CW-1:0]     fill_cur,
   output logic [WORD_W-1:0] top_cur,
   output logic [CW-1:0]     fill_nxt,
   output logic [WORD_W-1:0] top_nxt
);

   logic [WORD_W-1:0] store_ff [DEPTH];
   logic [WORD_W-1:0] rdata_ff;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [WORD_W-1:0] top_ff, top_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [CW-1:0]     rd_off;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] h);
      logic [AW-1:0] r;
      if (h == AW'(DEPTH - 1)) r = '0;
      else r = h + AW'(1);
      return r;
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] h);
      logic [AW-1:0] r;
      if (h == '0) r = AW'(DEPTH - 1);
      else r = h - AW'(1);
      return r;
   endfunction

   // Offset is at most DEPTH, so one conditional subtract wraps the sum
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h, input logic [CW-1:0] o);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(o);
      if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
      return s[AW-1:0];
   endfunction

   // Address the read for the incoming item from the state this cycle leaves
   always_comb begin
      rd_off = (fill_in == '0) ? '0 : fill_in - CW'(1);
      if (rd_kind == STK_RROT) rd_addr = wrap_add(head_in, rd_off);
      else rd_addr = wrap_inc(head_in);
   end

   // Memory: one write, one registered read, write data forwarded on a match
   always_ff @(posedge clock) begin
      if (wr_en) store_ff[wr_addr] <= wr_data;
      if (wr_en && (wr_addr == rd_addr)) rdata_ff <= wr_data;
      else rdata_ff <= store_ff[rd_addr];
   end

   // Execute the command against the registered top and fetched word
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      top_in  = top_ff;
      wr_en   = 1'b0;
      wr_addr = head_ff;
      wr_data = top_ff;
      unique case (cmd.kind)
         STK_SWAP: begin
            wr_en   = 1'b1;
            wr_addr = wrap_inc(head_ff);
            top_in  = rdata_ff;
         end
         STK_ROT: begin
            wr_en   = 1'b1;
            wr_addr = wrap_add(head_ff, fill_ff);
            head_in = wrap_inc(head_ff);
            top_in  = rdata_ff;
         end
         STK_RROT: begin
            wr_en   = 1'b1;
            head_in = wrap_dec(head_ff);
            top_in  = rdata_ff;
         end
         STK_POP: begin
            head_in = wrap_inc(head_ff);
            fill_in = fill_ff - CW'(1);
            top_in  = rdata_ff;
         end
         STK_PUSH: begin
            wr_en   = 1'b1;
            head_in = wrap_dec(head_ff);
            fill_in = fill_ff + CW'(1);
            top_in  = cmd.data;
         end
         STK_LOAD: begin
            fill_in = fill_ff + CW'(1);
            if (fill_ff == '0) begin
               top_in = cmd.data;
            end else begin
               wr_en   = 1'b1;
               wr_addr = wrap_add(head_ff, fill_ff);
               wr_data = cmd.data;
            end
         end
         STK_CLEAR: begin
            head_in = '0;
            fill_in = '0;
         end
         default: ;
      endcase
   end

   // Hold pointers and top word
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
      top_ff <= top_in;
   end

   assign fill_cur = fill_ff;
   assign top_cur  = top_ff;
   assign fill_nxt = fill_in;
   assign top_nxt  = top_in;

endmodule

// ===== src/dual_stack_rotate_engine_unit.sv =====
// An accepted item is registered into valid_ff, op_ff and value_ff, and its
// result then into the rsp_* registers that drive rsp_valid.
// Throughput: one item per cycle; each stack does one registered memory read
// and at most one write per item, with the read addressed in the accept cycle.
// Reset (synchronous) empties both stacks; memory contents are not cleared.
module dual_stack_rotate_engine_unit
   import dsre_pkg::*;
#(
   parameter int unsigned DEPTH = 512,
   localparam int unsigned CW = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic               rsp_emitted,
   output logic [1:0]         rsp_status,
   output logic [CW-1:0]      rsp_count_a,
   output logic [CW-1:0]      rsp_count_b,
   output logic signed [31:0] rsp_top_a,
   output logic signed [31:0] rsp_top_b
);

   logic              accept;
   logic              valid_ff;
   op_type            op_ff;
   logic [WORD_W-1:0] value_ff;

   stk_kind_type      rd_kind_a, rd_kind_b;
   stk_cmd_type       cmd_a, cmd_b;
   logic [CW-1:0]     fill_a_cur, fill_b_cur, fill_a_nxt, fill_b_nxt;
   logic [WORD_W-1:0] top_a_cur, top_b_cur, top_a_nxt, top_b_nxt;
   logic              two_a, two_b, full_a, full_b, empty_a, empty_b;

   logic              emitted_in;
   status_type        status_in;

   logic              rsp_valid_ff;
   logic              rsp_emitted_ff;
   status_type        rsp_status_ff;
   logic [CW-1:0]     rsp_count_a_ff, rsp_count_b_ff;
   logic [WORD_W-1:0] rsp_top_a_ff, rsp_top_b_ff;

   // Accept an item every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Pick which word each stack must fetch for the incoming item
   always_comb begin
      rd_kind_a = STK_NOP;
      rd_kind_b = STK_NOP;
      unique case (op_type'(req_opcode))
         OP_SA:  rd_kind_a = STK_SWAP;
         OP_SB:  rd_kind_b = STK_SWAP;
         OP_SS: begin
            rd_kind_a = STK_SWAP;
            rd_kind_b = STK_SWAP;
         end
         OP_PA:  rd_kind_b = STK_POP;
         OP_PB:  rd_kind_a = STK_POP;
         OP_RA:  rd_kind_a = STK_ROT;
         OP_RB:  rd_kind_b = STK_ROT;
         OP_RR: begin
            rd_kind_a = STK_ROT;
            rd_kind_b = STK_ROT;
         end
         OP_RRA: rd_kind_a = STK_RROT;
         OP_RRB: rd_kind_b = STK_RROT;
         OP_RRR: begin
            rd_kind_a = STK_RROT;
            rd_kind_b = STK_RROT;
         end
         default: ;
      endcase
   end

   // Register the item
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= accept;
      op_ff    <= op_type'(req_opcode);
      value_ff <= req_value;
   end

   assign two_a   = fill_a_cur >= CW'(2);
   assign two_b   = fill_b_cur >= CW'(2);
   assign full_a  = fill_a_cur >= CW'(DEPTH);
   assign full_b  = fill_b_cur >= CW'(DEPTH);
   assign empty_a = fill_a_cur == '0;
   assign empty_b = fill_b_cur == '0;

   // Decide the stack actions and the outcome of the registered item
   always_comb begin
      cmd_a      = '{kind: STK_NOP, data: '0};
      cmd_b      = '{kind: STK_NOP, data: '0};
      emitted_in = 1'b0;
      status_in  = STATUS_DONE;
      if (valid_ff) begin
         unique case (op_ff)
            OP_SA: begin
               if (two_a) cmd_a.kind = STK_SWAP;
               emitted_in = two_a;
               status_in  = two_a ? STATUS_DONE : STATUS_FEW;
            end
            OP_SB: begin
               if (two_b) cmd_b.kind = STK_SWAP;
               emitted_in = two_b;
               status_in  = two_b ? STATUS_DONE : STATUS_FEW;
            end
            OP_SS: begin
               if (two_a) cmd_a.kind = STK_SWAP;
               if (two_b) cmd_b.kind = STK_SWAP;
               emitted_in = 1'b1;
               status_in  = (two_a || two_b) ? STATUS_DONE : STATUS_FEW;
            end
            OP_PA: begin
               if (empty_b) begin
                  status_in = STATUS_FEW;
               end else if (full_a) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd_b.kind = STK_POP;
                  cmd_a.kind = STK_PUSH;
                  cmd_a.data = top_b_cur;
                  emitted_in = 1'b1;
               end
            end
            OP_PB: begin
               if (empty_a) begin
                  status_in = STATUS_FEW;
               end else if (full_b) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd_a.kind = STK_POP;
                  cmd_b.kind = STK_PUSH;
                  cmd_b.data = top_a_cur;
                  emitted_in = 1'b1;
               end
            end
            OP_RA: begin
               if (two_a) cmd_a.kind = STK_ROT;
               emitted_in = two_a;
               status_in  = two_a ? STATUS_DONE : STATUS_FEW;
            end
            OP_RB: begin
               if (two_b) cmd_b.kind = STK_ROT;
               emitted_in = two_b;
               status_in  = two_b ? STATUS_DONE : STATUS_FEW;
            end
            OP_RR: begin
               if (two_a) cmd_a.kind = STK_ROT;
               if (two_b) cmd_b.kind = STK_ROT;
               emitted_in = 1'b1;
               status_in  = (two_a || two_b) ? STATUS_DONE : STATUS_FEW;
            end
            OP_RRA: begin
               if (two_a) cmd_a.kind = STK_RROT;
               emitted_in = two_a;
               status_in  = two_a ? STATUS_DONE : STATUS_FEW;
            end
            OP_RRB: begin
               if (two_b) cmd_b.kind = STK_RROT;
               emitted_in = two_b;
               status_in  = two_b ? STATUS_DONE : STATUS_FEW;
            end
            OP_RRR: begin
               if (two_a) cmd_a.kind = STK_RROT;
               if (two_b) cmd_b.kind = STK_RROT;
               emitted_in = 1'b1;
               status_in  = (two_a || two_b) ? STATUS_DONE : STATUS_FEW;
            end
            OP_LOAD: begin
               if (full_a) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd_a.kind = STK_LOAD;
                  cmd_a.data = value_ff;
               end
            end
            OP_CLEAR: begin
               cmd_a.kind = STK_CLEAR;
               cmd_b.kind = STK_CLEAR;
            end
            default: ;
         endcase
      end
   end

   dsre_stack #(
      .DEPTH (DEPTH)
   ) u_stack_a (
      .clock    (clock),
      .reset    (reset),
      .rd_kind  (rd_kind_a),
      .cmd      (cmd_a),
      .fill_cur (fill_a_cur),
      .top_cur  (top_a_cur),
      .fill_nxt (fill_a_nxt),
      .top_nxt  (top_a_nxt)
   );

   dsre_stack #(
      .DEPTH (DEPTH)
   ) u_stack_b (
      .clock    (clock),
      .reset    (reset),
      .rd_kind  (rd_kind_b),
      .cmd      (cmd_b),
      .fill_cur (fill_b_cur),
      .top_cur  (top_b_cur),
      .fill_nxt (fill_b_nxt),
      .top_nxt  (top_b_nxt)
   );

   // Register the result; an empty stack shows a zero top
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= valid_ff;
      rsp_emitted_ff <= emitted_in;
      rsp_status_ff  <= status_in;
      rsp_count_a_ff <= fill_a_nxt;
      rsp_count_b_ff <= fill_b_nxt;
      rsp_top_a_ff   <= (fill_a_nxt == '0) ? '0 : top_a_nxt;
      rsp_top_b_ff   <= (fill_b_nxt == '0) ? '0 : top_b_nxt;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_emitted = rsp_emitted_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count_a = rsp_count_a_ff;
   assign rsp_count_b = rsp_count_b_ff;
   assign rsp_top_a   = rsp_top_a_ff;
   assign rsp_top_b   = rsp_top_b_ff;

endmodule

// ===== src/dsre_checker.sv =====
module dsre_checker
   import dsre_pkg::*;
#(
   parameter int unsigned DEPTH = 512,
   localparam int unsigned CW = $clog2(DEPTH + 1)
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [3:0]         req_opcode,
   input logic               rsp_valid,
   input logic               rsp_emitted,
   input logic [1:0]         rsp_status,
   input logic [CW-1:0]      rsp_count_a,
   input logic [CW-1:0]      rsp_count_b,
   input logic signed [31:0] rsp_top_a,
   input logic signed [31:0] rsp_top_b
);

   logic accept;
   assign accept = start && !busy;

   // Every accepted item gets its result once through the item and result registers
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted item produced no result");

   // No result without an accepted item that passed the item and result registers
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result without an accepted item");

   // Clear leaves both stacks empty, silent and done
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_CLEAR) |-> ##2
         (rsp_count_a == '0 && rsp_count_b == '0 && !rsp_emitted &&
          rsp_status == STATUS_DONE && rsp_top_a == '0 && rsp_top_b == '0))
      else $error("clear did not empty both stacks");

   // Combined swap and rotate always announce
   a_combined_emit: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_SS || req_opcode == OP_RR || req_opcode == OP_RRR))
         |-> ##2 rsp_emitted)
      else $error("combined operation not emitted");

   // Counts stay within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count_a <= CW'(DEPTH) && rsp_count_b <= CW'(DEPTH)))
      else $error("stack count beyond capacity");

endmodule

bind dual_stack_rotate_engine_unit dsre_checker #(.DEPTH(DEPTH)) u_dsre_checker (.*);

// ===== tb/sv/stack_result_checker.sv =====
module stack_result_checker
   import dsre_pkg::*;
#(
   parameter int unsigned DEPTH = 512,
   localparam int unsigned CW = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_emitted,
   input  logic [1:0]         rsp_status,
   input  logic [CW-1:0]      rsp_count_a,
   input  logic [CW-1:0]      rsp_count_b,
   input  logic signed [31:0] rsp_top_a,
   input  logic signed [31:0] rsp_top_b,
   output int                 mismatch_count,
   output int                 outstanding
);

   localparam int SIDE_A = 0;
   localparam int SIDE_B = 1;

   typedef struct packed {
      logic          emitted;
      status_type    status;
      logic [CW-1:0] count_a;
      logic [CW-1:0] count_b;
      logic [31:0]   top_a;
      logic [31:0]   top_b;
   } outcome_t;

   // Shadow copy of both stacks
   logic [31:0] stack_mem [2][DEPTH];
   int unsigned stack_head [2];
   int unsigned stack_fill [2];

   outcome_t outcome_queue[$];
   int       fails;

   function automatic bit swap_top(input int s);
      int unsigned p0;
      int unsigned p1;
      logic [31:0] t;
      if (stack_fill[s] < 2) return 1'b0;
      p0 = stack_head[s];
      p1 = (stack_head[s] + 1) % DEPTH;
      t = stack_mem[s][p0];
      stack_mem[s][p0] = stack_mem[s][p1];
      stack_mem[s][p1] = t;
      return 1'b1;
   endfunction

   function automatic bit rotate_up(input int s);
      int unsigned h;
      h = stack_head[s];
      if (stack_fill[s] < 2) return 1'b0;
      stack_mem[s][(h + stack_fill[s]) % DEPTH] = stack_mem[s][h];
      stack_head[s] = (h + 1) % DEPTH;
      return 1'b1;
   endfunction

   function automatic bit rotate_down(input int s);
      int unsigned h;
      int unsigned nh;
      h = stack_head[s];
      if (stack_fill[s] < 2) return 1'b0;
      nh = (h + DEPTH - 1) % DEPTH;
      stack_mem[s][nh] = stack_mem[s][(h + stack_fill[s] - 1) % DEPTH];
      stack_head[s] = nh;
      return 1'b1;
   endfunction

   // Move the top of src onto dst
   function automatic status_type push_across(input int src, input int dst);
      logic [31:0] v;
      if (stack_fill[src] == 0) return STATUS_FEW;
      if (stack_fill[dst] >= DEPTH) return STATUS_FULL;
      v = stack_mem[src][stack_head[src]];
      stack_head[src] = (stack_head[src] + 1) % DEPTH;
      stack_fill[src] = stack_fill[src] - 1;
      stack_head[dst] = (stack_head[dst] + DEPTH - 1) % DEPTH;
      stack_mem[dst][stack_head[dst]] = v;
      stack_fill[dst] = stack_fill[dst] + 1;
      return STATUS_DONE;
   endfunction

   // Execute one operation on the shadow stacks and return its outcome
   function automatic outcome_t apply_stack_op(input op_type op, input logic [31:0] val);
      outcome_t res;
      bit       a;
      bit       b;
      res = '0;
      res.status = STATUS_DONE;
      case (op)
         OP_SA, OP_RA, OP_RRA: begin
            a = (op == OP_SA) ? swap_top(SIDE_A) :
                (op == OP_RA) ? rotate_up(SIDE_A) : rotate_down(SIDE_A);
            res.emitted = a;
            res.status = a ? STATUS_DONE : STATUS_FEW;
         end
         OP_SB, OP_RB, OP_RRB: begin
            b = (op == OP_SB) ? swap_top(SIDE_B) :
                (op == OP_RB) ? rotate_up(SIDE_B) : rotate_down(SIDE_B);
            res.emitted = b;
            res.status = b ? STATUS_DONE : STATUS_FEW;
         end
         OP_SS, OP_RR, OP_RRR: begin
            if (op == OP_SS) begin
               a = swap_top(SIDE_A);
               b = swap_top(SIDE_B);
            end else if (op == OP_RR) begin
               a = rotate_up(SIDE_A);
               b = rotate_up(SIDE_B);
            end else begin
               a = rotate_down(SIDE_A);
               b = rotate_down(SIDE_B);
            end
            res.emitted = 1'b1;
            res.status = (a || b) ? STATUS_DONE : STATUS_FEW;
         end
         OP_PA, OP_PB: begin
            res.status = (op == OP_PA) ? push_across(SIDE_B, SIDE_A)
                                       : push_across(SIDE_A, SIDE_B);
            res.emitted = (res.status == STATUS_DONE);
         end
         OP_LOAD: begin
            if (stack_fill[SIDE_A] >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               stack_mem[SIDE_A][(stack_head[SIDE_A] + stack_fill[SIDE_A]) % DEPTH] = val;
               stack_fill[SIDE_A] = stack_fill[SIDE_A] + 1;
            end
         end
         OP_CLEAR: begin
            stack_head[SIDE_A] = 0;
            stack_fill[SIDE_A] = 0;
            stack_head[SIDE_B] = 0;
            stack_fill[SIDE_B] = 0;
         end
         default: ;
      endcase
      res.count_a = CW'(stack_fill[SIDE_A]);
      res.count_b = CW'(stack_fill[SIDE_B]);
      res.top_a = (stack_fill[SIDE_A] != 0) ? stack_mem[SIDE_A][stack_head[SIDE_A]] : '0;
      res.top_b = (stack_fill[SIDE_B] != 0) ? stack_mem[SIDE_B][stack_head[SIDE_B]] : '0;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fails++;
      end
   endfunction

   initial begin
      fails = 0;
      mismatch_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         // Hold the shadow stacks empty during reset
         outcome_queue.delete();
         stack_head[SIDE_A] = 0;
         stack_fill[SIDE_A] = 0;
         stack_head[SIDE_B] = 0;
         stack_fill[SIDE_B] = 0;
      end else begin
         // Compare the strobed result with the oldest prediction
         if (rsp_valid === 1'b1) begin
            if (outcome_queue.size() == 0) begin
               $error("result strobed with no item outstanding");
               fails++;
            end else begin
               want = outcome_queue.pop_front();
               check_field("emitted", 32'(want.emitted), 32'(rsp_emitted));
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("count_a", 32'(want.count_a), 32'(rsp_count_a));
               check_field("count_b", 32'(want.count_b), 32'(rsp_count_b));
               check_field("top_a", want.top_a, rsp_top_a);
               check_field("top_b", want.top_b, rsp_top_b);
            end
         end else if (rsp_valid !== 1'b0) begin
            $error("rsp_valid unknown");
            fails++;
         end
         // Predict the outcome of an accepted item
         if (start && !busy) begin
            outcome_queue.push_back(apply_stack_op(op_type'(req_opcode), req_value));
         end
      end
      outstanding <= outcome_queue.size();
      mismatch_count <= fails;
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import dsre_pkg::*;

   localparam int unsigned DEPTH = 512;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int CYCLE_LIMIT = 400000;

   // Operations that leave both counts unchanged
   localparam op_type STEADY_OPS [9] = '{OP_SA, OP_SB, OP_SS, OP_RA, OP_RB, OP_RR,
                                         OP_RRA, OP_RRB, OP_RRR};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [3:0]         req_opcode = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_emitted;
   logic [1:0]         rsp_status;
   logic [CW-1:0]      rsp_count_a;
   logic [CW-1:0]      rsp_count_b;
   logic signed [31:0] rsp_top_a;
   logic signed [31:0] rsp_top_b;
   int                 mismatch_count;
   int                 outstanding;
   int                 cycle_count = 0;
   bit                 pacing_on = 1'b1;

   always #1 clock = ~clock;

   dual_stack_rotate_engine_unit #(.DEPTH(DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_emitted (rsp_emitted),
      .rsp_status  (rsp_status),
      .rsp_count_a (rsp_count_a),
      .rsp_count_b (rsp_count_b),
      .rsp_top_a   (rsp_top_a),
      .rsp_top_b   (rsp_top_b)
   );

   stack_result_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_emitted    (rsp_emitted),
      .rsp_status     (rsp_status),
      .rsp_count_a    (rsp_count_a),
      .rsp_count_b    (rsp_count_b),
      .rsp_top_a      (rsp_top_a),
      .rsp_top_b      (rsp_top_b),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic op_type pick_steady_op();
      return STEADY_OPS[$urandom_range(0, 8)];
   endfunction

   function automatic op_type pick_mixed_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return OP_LOAD;
      if (r < 32) return OP_PA;
      if (r < 44) return OP_PB;
      if (r < 45) return OP_CLEAR;
      return pick_steady_op();
   endfunction

   // Drop start for a random burst, with noise on the request ports
   task automatic idle_burst();
      start <= 1'b0;
      req_opcode <= 4'($urandom_range(0, 12));
      req_value <= $urandom;
      repeat ($urandom_range(1, 16)) @(posedge clock);
   endtask

   // Present one item and hold it until the block takes it
   task automatic send_item(input op_type op, input logic [31:0] val);
      start <= 1'b1;
      req_opcode <= op;
      req_value <= val;
      do @(posedge clock); while (busy);
      if (pacing_on && $urandom_range(0, 3) == 0) idle_burst();
   endtask

   // Hold off the next item until every result is back
   task automatic wait_all_done();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int loads;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation but clear on empty stacks, then small stacks
      send_item(OP_SA, rand_word());
      send_item(OP_SB, rand_word());
      send_item(OP_SS, rand_word());
      send_item(OP_PA, rand_word());
      send_item(OP_PB, rand_word());
      send_item(OP_RA, rand_word());
      send_item(OP_RB, rand_word());
      send_item(OP_RR, rand_word());
      send_item(OP_RRA, rand_word());
      send_item(OP_RRB, rand_word());
      send_item(OP_RRR, rand_word());
      send_item(OP_LOAD, 32'h8000_0000);
      send_item(OP_LOAD, 32'h7FFF_FFFF);
      send_item(OP_LOAD, 32'hFFFF_FFFF);
      send_item(OP_LOAD, 32'h0000_0000);
      send_item(OP_SA, rand_word());
      send_item(OP_RA, rand_word());
      send_item(OP_RRA, rand_word());
      send_item(OP_PB, rand_word());
      send_item(OP_PB, rand_word());
      send_item(OP_SB, rand_word());
      send_item(OP_SS, rand_word());
      send_item(OP_RR, rand_word());
      send_item(OP_PA, rand_word());
      // only A has at least two elements here
      send_item(OP_RRR, rand_word());
      send_item(OP_CLEAR, rand_word());
      wait_all_done();

      // Fill A to the brim and past it
      loads = 0;
      while (loads < DEPTH + 4) begin
         if ($urandom_range(0, 7) == 0) begin
            send_item(pick_steady_op(), rand_word());
         end else begin
            send_item(OP_LOAD, rand_word());
            loads++;
         end
      end
      // B is empty: nothing to move
      send_item(OP_PA, rand_word());
      repeat (3) send_item(OP_PB, rand_word());
      repeat (4) send_item(OP_LOAD, rand_word());
      // A is full again
      send_item(OP_PA, rand_word());
      wait_all_done();

      // Random mix; switch pacing every sixty items, none at the tail
      for (int i = 0; i < 180; i++) begin
         if (i % 60 == 0) pacing_on = (i < 120) && ($urandom_range(0, 2) != 0);
         send_item(pick_mixed_op(), rand_word());
      end

      // Drain and give the verdict
      wait_all_done();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
